// ===== rtl/dcp_pkg.sv =====
// Shared types, codes and constants for the DCP response block parser.
package dcp_pkg;

   localparam int unsigned MAX_FRAME_LEN = 65535;
   localparam logic [15:0] HDR_LEN_HI    = 16'd24;
   localparam logic [15:0] HDR_LEN_LO    = 16'd25;
   localparam logic [16:0] BLOCKS_START  = 17'd26;
   localparam logic [7:0]  OPT_IP        = 8'h01;
   localparam logic [7:0]  OPT_DEVICE    = 8'h02;
   localparam logic [7:0]  SUB_ONE       = 8'h01;
   localparam logic [7:0]  SUB_TWO       = 8'h02;
   localparam logic [7:0]  CHAR_DOT      = 8'h2E;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_OPTION = 3'd1,
      PH_SUBOPT = 3'd2,
      PH_LEN_HI = 3'd3,
      PH_LEN_LO = 3'd4,
      PH_INFO   = 3'd5,
      PH_BODY   = 3'd6,
      PH_PAD    = 3'd7
   } phase_type;

   typedef enum logic [1:0] {
      KIND_OTHER   = 2'd0,
      KIND_FAMILY  = 2'd1,
      KIND_STATION = 2'd2,
      KIND_IP      = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_GOOD      = 2'd0,
      STAT_LEN_BAD   = 2'd1,
      STAT_BLOCK_BAD = 2'd2
   } status_type;

   // One classified request on its way from the parser to the result side.
   typedef struct packed {
      logic [7:0]  option;
      logic [7:0]  suboption;
      kind_type    kind;
      logic [7:0]  data;
      logic        valid;
      logic [15:0] offset;
      logic        last;
      logic        len_bad;
      logic        blk_bad;
   } entry_type;

   function automatic kind_type kind_of(input logic [7:0] opt, input logic [7:0] sub);
      kind_type k;
      k = KIND_OTHER;
      if (opt == OPT_DEVICE && sub == SUB_ONE) k = KIND_FAMILY;
      else if (opt == OPT_DEVICE && sub == SUB_TWO) k = KIND_STATION;
      else if (opt == OPT_IP && sub == SUB_TWO) k = KIND_IP;
      return k;
   endfunction

endpackage

// ===== rtl/dcp_front.sv =====
// Front end: walks the frame byte by byte and classifies each request.
module dcp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          frame_byte,
   input  logic                last_byte,
   output logic                wr_en,
   output dcp_pkg::entry_type  wr_entry
);

   logic [15:0]        pos_ff, pos_in;
   logic [15:0]        dlen_ff, dlen_in;
   dcp_pkg::phase_type phase_ff, phase_in;
   logic [7:0]         opt_ff, opt_in;
   logic [7:0]         sub_ff, sub_in;
   logic [15:0]        blen_ff, blen_in;
   logic [15:0]        cnt_ff, cnt_in;
   logic               dot_ff, dot_in;
   logic               err_ff, err_in;

   logic               deliver;
   dcp_pkg::kind_type  kind;
   logic [16:0]        len_total;
   logic [15:0]        cnt_inc;
   logic [15:0]        body_len;

   assign kind     = dcp_pkg::kind_of(opt_ff, sub_ff);
   assign cnt_inc  = cnt_ff + 16'd1;
   assign body_len = blen_ff - 16'd2;

   always_comb begin
      pos_in   = (pos_ff == 16'hFFFF) ? pos_ff : pos_ff + 16'd1;
      dlen_in  = dlen_ff;
      phase_in = phase_ff;
      opt_in   = opt_ff;
      sub_in   = sub_ff;
      blen_in  = blen_ff;
      cnt_in   = cnt_ff;
      dot_in   = dot_ff;
      err_in   = err_ff;
      deliver  = 1'b0;
      if (!err_ff) begin
         case (phase_ff)
            dcp_pkg::PH_HEADER: begin
               if (pos_ff == dcp_pkg::HDR_LEN_HI) dlen_in = {frame_byte, dlen_ff[7:0]};
               if (pos_ff == dcp_pkg::HDR_LEN_LO) begin
                  dlen_in  = {dlen_ff[15:8], frame_byte};
                  phase_in = dcp_pkg::PH_OPTION;
               end
            end
            dcp_pkg::PH_OPTION: begin
               opt_in   = frame_byte;
               dot_in   = 1'b0;
               phase_in = dcp_pkg::PH_SUBOPT;
            end
            dcp_pkg::PH_SUBOPT: begin
               sub_in   = frame_byte;
               phase_in = dcp_pkg::PH_LEN_HI;
            end
            dcp_pkg::PH_LEN_HI: begin
               blen_in  = {frame_byte, 8'h00};
               phase_in = dcp_pkg::PH_LEN_LO;
            end
            dcp_pkg::PH_LEN_LO: begin
               blen_in = {blen_ff[15:8], frame_byte};
               if ({blen_ff[15:8], frame_byte} < 16'd2) begin
                  err_in = 1'b1;
               end else begin
                  cnt_in   = '0;
                  phase_in = dcp_pkg::PH_INFO;
               end
            end
            dcp_pkg::PH_INFO: begin
               if (cnt_ff == 16'd0) begin
                  cnt_in = 16'd1;
               end else if (blen_ff == 16'd2) begin
                  cnt_in   = '0;
                  phase_in = blen_ff[0] ? dcp_pkg::PH_PAD : dcp_pkg::PH_OPTION;
               end else begin
                  cnt_in   = '0;
                  phase_in = dcp_pkg::PH_BODY;
               end
            end
            dcp_pkg::PH_BODY: begin
               // Suppress the station name from its first dot on.
               if (kind == dcp_pkg::KIND_STATION && frame_byte == dcp_pkg::CHAR_DOT)
                  dot_in = 1'b1;
               deliver = !(kind == dcp_pkg::KIND_STATION && dot_in);
               cnt_in  = cnt_inc;
               if (cnt_inc >= body_len) begin
                  cnt_in   = '0;
                  phase_in = blen_ff[0] ? dcp_pkg::PH_PAD : dcp_pkg::PH_OPTION;
               end
            end
            default: phase_in = dcp_pkg::PH_OPTION;
         endcase
      end
   end

   assign len_total = {1'b0, pos_ff} + 17'd1;

   always_comb begin
      wr_entry           = '0;
      wr_en              = accept && (deliver || last_byte);
      if (deliver) begin
         wr_entry.option    = opt_ff;
         wr_entry.suboption = sub_ff;
         wr_entry.kind      = kind;
         wr_entry.data      = frame_byte;
         wr_entry.valid     = 1'b1;
         wr_entry.offset    = cnt_ff;
      end
      wr_entry.last    = last_byte;
      wr_entry.len_bad = (len_total < dcp_pkg::BLOCKS_START)
                      || (len_total > 17'(dcp_pkg::MAX_FRAME_LEN))
                      || (len_total != dcp_pkg::BLOCKS_START + {1'b0, dlen_in});
      wr_entry.blk_bad = err_in || (phase_in != dcp_pkg::PH_OPTION);
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && last_byte)) begin
         pos_ff   <= '0;
         dlen_ff  <= '0;
         phase_ff <= dcp_pkg::PH_HEADER;
         opt_ff   <= '0;
         sub_ff   <= '0;
         blen_ff  <= '0;
         cnt_ff   <= '0;
         dot_ff   <= 1'b0;
         err_ff   <= 1'b0;
      end else if (accept) begin
         pos_ff   <= pos_in;
         dlen_ff  <= dlen_in;
         phase_ff <= phase_in;
         opt_ff   <= opt_in;
         sub_ff   <= sub_in;
         blen_ff  <= blen_in;
         cnt_ff   <= cnt_in;
         dot_ff   <= dot_in;
         err_ff   <= err_in;
      end
   end

endmodule

// ===== rtl/dcp_queue.sv =====
// Short queue between the parser and the result side.
module dcp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  dcp_pkg::entry_type  wr_entry,
   input  logic                rd_en,
   output logic                q_full,
   output logic                q_empty,
   output dcp_pkg::entry_type  rd_entry
);

   dcp_pkg::entry_type                    slot_ff [dcp_pkg::QUEUE_DEPTH];
   logic [dcp_pkg::QPTR_W-1:0]            wptr_ff, wptr_in;
   logic [dcp_pkg::QPTR_W-1:0]            rptr_ff, rptr_in;
   logic [dcp_pkg::QCNT_W-1:0]            cnt_ff, cnt_in;
   logic                                  do_wr, do_rd;

   assign q_full   = (cnt_ff == dcp_pkg::QCNT_W'(dcp_pkg::QUEUE_DEPTH));
   assign q_empty  = (cnt_ff == '0);
   assign do_wr    = wr_en && !q_full;
   assign do_rd    = rd_en && !q_empty;
   assign rd_entry = slot_ff[rptr_ff];

   always_comb begin
      wptr_in = do_wr ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = do_rd ? rptr_ff + 1'b1 : rptr_ff;
      cnt_in  = cnt_ff;
      if (do_wr && !do_rd) cnt_in = cnt_ff + 1'b1;
      else if (do_rd && !do_wr) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) slot_ff[wptr_ff] <= wr_entry;
   end

endmodule

// ===== rtl/dcp_back.sv =====
// Result side: resolves the frame status and drives the result fields.
module dcp_back (
   input  dcp_pkg::entry_type  head,
   output logic [7:0]          block_option,
   output logic [7:0]          block_suboption,
   output logic [1:0]          field_kind,
   output logic [7:0]          body_byte,
   output logic                body_valid,
   output logic [15:0]         body_offset,
   output logic                frame_end,
   output logic [1:0]          frame_status
);

   dcp_pkg::status_type status;

   // Length mismatch wins over block errors.
   always_comb begin
      status = dcp_pkg::STAT_GOOD;
      if (head.last) begin
         if (head.len_bad) status = dcp_pkg::STAT_LEN_BAD;
         else if (head.blk_bad) status = dcp_pkg::STAT_BLOCK_BAD;
      end
   end

   assign block_option    = head.option;
   assign block_suboption = head.suboption;
   assign field_kind      = head.kind;
   assign body_byte       = head.data;
   assign body_valid      = head.valid;
   assign body_offset     = head.offset;
   assign frame_end       = head.last;
   assign frame_status    = status;

endmodule

// ===== rtl/dcp_response_block_parser_core.sv =====
// Top level of the DCP identify-response block parser.
//
//   channel   direction  handshake           payload
//   request   in         push / full         req_frame_byte, req_last_byte
//   result    out        empty / pop         rsp_block_option .. rsp_frame_status
//
// One request is taken every cycle while full is low; the parser updates its counters
// and phase in the cycle the byte is accepted and writes a result into a four-entry queue
// the same cycle. Results are registered there and shown on the rsp_ ports from its head.
// full rises only when the queue holds four unpopped results.
// reset is synchronous and clears the parser state and the queue; a frame's last byte
// also returns the parser to its reset state.
module dcp_response_block_parser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_last_byte,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_block_option,
   output logic [7:0]  rsp_block_suboption,
   output logic [1:0]  rsp_field_kind,
   output logic [7:0]  rsp_body_byte,
   output logic        rsp_body_valid,
   output logic [15:0] rsp_body_offset,
   output logic        rsp_frame_end,
   output logic [1:0]  rsp_frame_status
);

   logic               accept;
   logic               wr_en;
   dcp_pkg::entry_type wr_entry;
   dcp_pkg::entry_type head;

   assign accept = push && !full;

   dcp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .frame_byte (req_frame_byte),
      .last_byte  (req_last_byte),
      .wr_en      (wr_en),
      .wr_entry   (wr_entry)
   );

   dcp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_entry (wr_entry),
      .rd_en    (pop),
      .q_full   (full),
      .q_empty  (empty),
      .rd_entry (head)
   );

   dcp_back u_back (
      .head            (head),
      .block_option    (rsp_block_option),
      .block_suboption (rsp_block_suboption),
      .field_kind      (rsp_field_kind),
      .body_byte       (rsp_body_byte),
      .body_valid      (rsp_body_valid),
      .body_offset     (rsp_body_offset),
      .frame_end       (rsp_frame_end),
      .frame_status    (rsp_frame_status)
   );

endmodule

// ===== tb/testbench.sv =====
// Testbench for the DCP identify-response block parser: directed frames, then random frames.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // One expected or observed result, one member per result port.
   typedef struct packed {
      logic [7:0]  option;
      logic [7:0]  suboption;
      logic [1:0]  kind;
      logic [7:0]  data;
      logic        valid;
      logic [15:0] offset;
      logic        fend;
      logic [1:0]  status;
   } parsed_type;

   // One directed frame: header bytes, data length field, block bytes (right-aligned,
   // first byte highest) and, where it can be read off directly, the end status.
   typedef struct packed {
      int                  hdr_n;
      logic [7:0]          fill;
      logic [15:0]         dlen;
      int                  nblk;
      logic [255:0]        blk;
      logic                typed;
      dcp_pkg::status_type st;
   } frame_row_type;

   localparam int N_ROWS = 16;

   frame_row_type dir_rows [N_ROWS] = '{
      // single byte frame
      '{1,  8'h00, 16'h0000, 0,  256'h0, 1'b1, dcp_pkg::STAT_LEN_BAD},
      // ends inside the length field
      '{25, 8'hFF, 16'h0000, 0,  256'h0, 1'b1, dcp_pkg::STAT_LEN_BAD},
      // header only, no blocks
      '{26, 8'h00, 16'h0000, 0,  256'h0, 1'b1, dcp_pkg::STAT_GOOD},
      // family, odd length with pad
      '{26, 8'h5A, 16'h000A, 10, 256'h02010005000041424300, 1'b1, dcp_pkg::STAT_GOOD},
      // station name, bytes from the dot on are dropped
      '{26, 8'hA5, 16'h000C, 12, 256'h02020008000061622E636465, 1'b1, dcp_pkg::STAT_GOOD},
      // IP parameters, last byte delivered
      '{26, 8'h00, 16'h0012, 18, 256'h0102000E0000C0A80001FFFFFF00C0A800FE, 1'b0,
        dcp_pkg::STAT_GOOD},
      // empty station body, then family with pad
      '{26, 8'h33, 16'h000E, 14, 256'h020200020000020100030000FF00, 1'b1, dcp_pkg::STAT_GOOD},
      // all ones
      '{26, 8'hFF, 16'h0008, 8,  256'hFFFF0003FFFFFFFF, 1'b1, dcp_pkg::STAT_GOOD},
      // block length one
      '{26, 8'h00, 16'h0006, 6,  256'h02010001AABB, 1'b1, dcp_pkg::STAT_BLOCK_BAD},
      // block length zero
      '{26, 8'h00, 16'h0004, 4,  256'h01020000, 1'b1, dcp_pkg::STAT_BLOCK_BAD},
      // frame ends in block info
      '{26, 8'hC3, 16'h0005, 5,  256'h0101000600, 1'b1, dcp_pkg::STAT_BLOCK_BAD},
      // frame ends where the pad belongs
      '{26, 8'h00, 16'h0007, 7,  256'h0201000300007F, 1'b0, dcp_pkg::STAT_GOOD},
      // data length one too large
      '{26, 8'h00, 16'h0009, 8,  256'h0201000300004100, 1'b1, dcp_pkg::STAT_LEN_BAD},
      // data length at its top
      '{26, 8'h00, 16'hFFFF, 6,  256'h010100020000, 1'b1, dcp_pkg::STAT_LEN_BAD},
      // block past a zero data length still delivers
      '{26, 8'h00, 16'h0000, 8,  256'h0101000300005500, 1'b1, dcp_pkg::STAT_LEN_BAD},
      // dot first, dot tracking restarts at the next block
      '{26, 8'h00, 16'h0010, 16, 256'h0202000400002E410202000300004200, 1'b1,
        dcp_pkg::STAT_GOOD}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [7:0]  req_frame_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        empty;
   logic        pop = 1'b0;
   logic [7:0]  rsp_block_option;
   logic [7:0]  rsp_block_suboption;
   logic [1:0]  rsp_field_kind;
   logic [7:0]  rsp_body_byte;
   logic        rsp_body_valid;
   logic [15:0] rsp_body_offset;
   logic        rsp_frame_end;
   logic [1:0]  rsp_frame_status;

   // parser state mirror
   logic [15:0]        pos = '0;
   logic [15:0]        dlen = '0;
   dcp_pkg::phase_type phase = dcp_pkg::PH_HEADER;
   logic [7:0]         cur_opt = '0;
   logic [7:0]         cur_sub = '0;
   logic [15:0]        cur_len = '0;
   logic [15:0]        body_cnt = '0;
   logic               dot_hit = 1'b0;
   logic               blk_err = 1'b0;

   parsed_type expected_rsp [$];
   int         fail_count = 0;
   int         sent_items = 0;
   bit         snd_idle_en = 1'b0;
   bit         rsp_idle_en = 1'b0;
   bit         hold_rsp = 1'b0;

   dcp_response_block_parser_core dut (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .full                (full),
      .req_frame_byte      (req_frame_byte),
      .req_last_byte       (req_last_byte),
      .empty               (empty),
      .pop                 (pop),
      .rsp_block_option    (rsp_block_option),
      .rsp_block_suboption (rsp_block_suboption),
      .rsp_field_kind      (rsp_field_kind),
      .rsp_body_byte       (rsp_body_byte),
      .rsp_body_valid      (rsp_body_valid),
      .rsp_body_offset     (rsp_body_offset),
      .rsp_frame_end       (rsp_frame_end),
      .rsp_frame_status    (rsp_frame_status)
   );

   always #6 clock = ~clock;

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic void close_body();
      body_cnt = '0;
      phase = cur_len[0] ? dcp_pkg::PH_PAD : dcp_pkg::PH_OPTION;
   endfunction

   // Advance the parser mirror by one request; return 1 when it yields a result.
   function automatic bit parse_byte(input logic [7:0] b, input logic fin,
                                     output parsed_type r);
      logic              deliver;
      logic [16:0]       flen;
      dcp_pkg::kind_type k;
      deliver = 1'b0;
      r = '0;
      flen = {1'b0, pos} + 17'd1;
      if (!blk_err) begin
         case (phase)
            dcp_pkg::PH_HEADER: begin
               if (pos == dcp_pkg::HDR_LEN_HI) dlen[15:8] = b;
               if (pos == dcp_pkg::HDR_LEN_LO) begin
                  dlen[7:0] = b;
                  phase = dcp_pkg::PH_OPTION;
               end
            end
            dcp_pkg::PH_OPTION: begin
               cur_opt = b;
               dot_hit = 1'b0;
               phase = dcp_pkg::PH_SUBOPT;
            end
            dcp_pkg::PH_SUBOPT: begin
               cur_sub = b;
               phase = dcp_pkg::PH_LEN_HI;
            end
            dcp_pkg::PH_LEN_HI: begin
               cur_len = {b, 8'h00};
               phase = dcp_pkg::PH_LEN_LO;
            end
            dcp_pkg::PH_LEN_LO: begin
               cur_len[7:0] = b;
               if (cur_len < 16'd2) begin
                  blk_err = 1'b1;
               end else begin
                  body_cnt = '0;
                  phase = dcp_pkg::PH_INFO;
               end
            end
            dcp_pkg::PH_INFO: begin
               if (body_cnt == 16'd0) body_cnt = 16'd1;
               else if (cur_len == 16'd2) close_body();
               else begin
                  body_cnt = '0;
                  phase = dcp_pkg::PH_BODY;
               end
            end
            dcp_pkg::PH_BODY: begin
               if (cur_opt == dcp_pkg::OPT_DEVICE && cur_sub == dcp_pkg::SUB_ONE)
                  k = dcp_pkg::KIND_FAMILY;
               else if (cur_opt == dcp_pkg::OPT_DEVICE && cur_sub == dcp_pkg::SUB_TWO)
                  k = dcp_pkg::KIND_STATION;
               else if (cur_opt == dcp_pkg::OPT_IP && cur_sub == dcp_pkg::SUB_TWO)
                  k = dcp_pkg::KIND_IP;
               else
                  k = dcp_pkg::KIND_OTHER;
               if (k == dcp_pkg::KIND_STATION && b == dcp_pkg::CHAR_DOT) dot_hit = 1'b1;
               if (!(k == dcp_pkg::KIND_STATION && dot_hit)) begin
                  deliver = 1'b1;
                  r.option = cur_opt;
                  r.suboption = cur_sub;
                  r.kind = k;
                  r.data = b;
                  r.valid = 1'b1;
                  r.offset = body_cnt;
               end
               body_cnt = body_cnt + 16'd1;
               if ({1'b0, body_cnt} >= {1'b0, cur_len} - 17'd2) close_body();
            end
            default: phase = dcp_pkg::PH_OPTION;
         endcase
      end
      if (pos != 16'hFFFF) pos = pos + 16'd1;
      if (!deliver && !fin) return 1'b0;
      r.fend = fin;
      if (fin) begin
         if (flen < dcp_pkg::BLOCKS_START || {15'd0, flen} > dcp_pkg::MAX_FRAME_LEN ||
             flen != dcp_pkg::BLOCKS_START + {1'b0, dlen})
            r.status = dcp_pkg::STAT_LEN_BAD;
         else if (blk_err || phase != dcp_pkg::PH_OPTION)
            r.status = dcp_pkg::STAT_BLOCK_BAD;
         else
            r.status = dcp_pkg::STAT_GOOD;
         // frame done: back to the reset state
         pos = '0;
         dlen = '0;
         phase = dcp_pkg::PH_HEADER;
         cur_opt = '0;
         cur_sub = '0;
         cur_len = '0;
         body_cnt = '0;
         dot_hit = 1'b0;
         blk_err = 1'b0;
      end
      return 1'b1;
   endfunction

   // Offer every byte of a frame, marking the final one; record each expected result.
   task automatic send_frame(input logic [7:0] fr[$], input bit typed,
                             input dcp_pkg::status_type st);
      parsed_type want;
      logic       fin;
      for (int i = 0; i < fr.size(); i++) begin
         fin = (i == fr.size() - 1);
         if (snd_idle_en && $urandom_range(0, 4) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
         push <= 1'b1;
         req_frame_byte <= fr[i];
         req_last_byte <= fin;
         do @(posedge clock); while (full);
         if (parse_byte(fr[i], fin, want)) begin
            if (fin && typed) begin
               want = '0;
               want.fend = 1'b1;
               want.status = st;
            end
            expected_rsp.insert(expected_rsp.size(), want);
         end
         sent_items++;
         @(negedge clock);
      end
   endtask

   // Hold the sender until every expected result has come back.
   task automatic drain_results();
      push <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin : rsp_side
      pop = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            pop <= 1'b0;
            for (int n = 0; n < 300; n++) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (rsp_idle_en && $urandom_range(0, 4) == 0) begin
            pop <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
         pop <= 1'b1;
      end
   end

   always @(posedge clock) begin : rsp_check
      parsed_type got;
      parsed_type want;
      if (!reset && pop && !empty) begin
         got.option = rsp_block_option;
         got.suboption = rsp_block_suboption;
         got.kind = rsp_field_kind;
         got.data = rsp_body_byte;
         got.valid = rsp_body_valid;
         got.offset = rsp_body_offset;
         got.fend = rsp_frame_end;
         got.status = rsp_frame_status;
         if (expected_rsp.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("%0t extra opt=%h sub=%h kind=%0d data=%h v=%b off=%0d end=%b st=%0d",
                        $realtime, got.option, got.suboption, got.kind, got.data, got.valid,
                        got.offset, got.fend, got.status);
         end else begin
            want = expected_rsp.pop_front();
            if (got.option !== want.option || got.suboption !== want.suboption ||
                got.kind !== want.kind || got.data !== want.data ||
                got.valid !== want.valid || got.offset !== want.offset ||
                got.fend !== want.fend || got.status !== want.status) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("%0t exp opt=%h sub=%h kind=%0d data=%h v=%b off=%0d end=%b st=%0d",
                           $realtime, want.option, want.suboption, want.kind, want.data,
                           want.valid, want.offset, want.fend, want.status);
                  $display("%0t got opt=%h sub=%h kind=%0d data=%h v=%b off=%0d end=%b st=%0d",
                           $realtime, got.option, got.suboption, got.kind, got.data,
                           got.valid, got.offset, got.fend, got.status);
               end
            end
         end
      end
   end

   initial begin : stimulus
      logic [7:0]    fr [$];
      frame_row_type row;
      int            frame_idx;
      int            nb;
      int            flaw;
      int            blen;
      logic [15:0]   blk_len;
      logic [7:0]    opt;
      logic [7:0]    sub;
      logic [15:0]   len_field;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed frames
      snd_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
      for (int r = 0; r < N_ROWS; r++) begin
         row = dir_rows[r];
         fr.delete();
         for (int j = 0; j < row.hdr_n; j++)
            fr.insert(fr.size(), j == 24 ? row.dlen[15:8] : j == 25 ? row.dlen[7:0] : row.fill);
         for (int j = 0; j < row.nblk; j++)
            fr.insert(fr.size(), row.blk[(row.nblk - 1 - j) * 8 +: 8]);
         send_frame(fr, row.typed, row.st);
      end
      drain_results();

      // random frames, mostly well formed
      frame_idx = 0;
      while (sent_items < 1100) begin
         if (sent_items > 950) begin
            snd_idle_en = 1'b0;
            rsp_idle_en = 1'b0;
         end else begin
            snd_idle_en = ($urandom_range(0, 2) != 0);
            rsp_idle_en = ($urandom_range(0, 2) != 0);
         end
         // stall the result side for a long stretch while requests keep coming
         if (frame_idx == 1) hold_rsp = 1'b1;
         if (frame_idx == 3) drain_results();
         fr.delete();
         if ($urandom_range(0, 11) == 0) begin
            repeat ($urandom_range(1, 40)) fr.insert(fr.size(), 8'($urandom_range(0, 255)));
         end else begin
            repeat (24) fr.insert(fr.size(), 8'($urandom_range(0, 255)));
            fr.insert(fr.size(), 8'h00);
            fr.insert(fr.size(), 8'h00);
            nb = $urandom_range(1, 6);
            flaw = $urandom_range(0, 9);
            repeat (nb) begin
               case ($urandom_range(0, 4))
                  0: begin opt = dcp_pkg::OPT_DEVICE; sub = dcp_pkg::SUB_ONE; end
                  1: begin opt = dcp_pkg::OPT_DEVICE; sub = dcp_pkg::SUB_TWO; end
                  2: begin opt = dcp_pkg::OPT_IP; sub = dcp_pkg::SUB_TWO; end
                  3: begin opt = dcp_pkg::OPT_DEVICE; sub = 8'($urandom_range(0, 255)); end
                  default: begin
                     opt = 8'($urandom_range(0, 255));
                     sub = 8'($urandom_range(0, 255));
                  end
               endcase
               blen = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 300)
                                                   : $urandom_range(0, 24);
               blk_len = 16'(blen + 2);
               fr.insert(fr.size(), opt);
               fr.insert(fr.size(), sub);
               fr.insert(fr.size(), blk_len[15:8]);
               fr.insert(fr.size(), blk_len[7:0]);
               fr.insert(fr.size(), 8'($urandom_range(0, 255)));
               fr.insert(fr.size(), 8'($urandom_range(0, 255)));
               for (int j = 0; j < blen; j++) begin
                  if (opt == dcp_pkg::OPT_DEVICE && sub == dcp_pkg::SUB_TWO)
                     fr.insert(fr.size(), $urandom_range(0, 9) == 0 ? dcp_pkg::CHAR_DOT
                                             : 8'($urandom_range(8'h41, 8'h7A)));
                  else
                     fr.insert(fr.size(), 8'($urandom_range(0, 255)));
               end
               if (blk_len[0]) fr.insert(fr.size(), 8'($urandom_range(0, 255)));
            end
            case (flaw)
               7: repeat ($urandom_range(1, 6)) void'(fr.pop_back());
               9: begin
                  fr.insert(fr.size(), 8'($urandom_range(0, 255)));
                  fr.insert(fr.size(), 8'($urandom_range(0, 255)));
                  fr.insert(fr.size(), 8'h00);
                  fr.insert(fr.size(), 8'($urandom_range(0, 1)));
                  repeat ($urandom_range(0, 10)) fr.insert(fr.size(), 8'($urandom_range(0, 255)));
               end
               default: ;
            endcase
            len_field = 16'(fr.size() - 26);
            if (flaw == 8)
               len_field = ($urandom_range(0, 1) != 0) ? len_field + 16'($urandom_range(1, 3))
                                                       : len_field - 16'd1;
            fr[24] = len_field[15:8];
            fr[25] = len_field[7:0];
         end
         send_frame(fr, 1'b0, dcp_pkg::STAT_GOOD);
         frame_idx++;
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
